// ===== rtl/bop_pkg.sv =====
// Shared types and constants for the binomial option pricer.
package bop_pkg;
  localparam int PRICE_W = 40;
  localparam int FACT_W  = 32;
  localparam int STEPS_W = 9;
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
  localparam logic [STEPS_W-1:0] STEPS_RESET = 9'd64;
  localparam logic PAY_CALL = 1'b0;
  localparam logic PAY_PUT  = 1'b1;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,    // leaf = spot
    OP_MULD,    // leaf = leaf * down
    OP_MULU,    // leaf = leaf * up
    OP_LEAF,    // store payoff(leaf) at wr_addr
    OP_RD,      // issue store reads at rd_addr and rd_addr+1
    OP_IND      // store induction of read data at wr_addr
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [12:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [PRICE_W-1:0] spot;
    logic [PRICE_W-1:0] strike;
    logic               is_put;
    logic [FACT_W-1:0]  up;
    logic [FACT_W-1:0]  down;
    logic [FACT_W-1:0]  pu;
    logic [FACT_W-1:0]  pd;
  } item_t;

  function automatic logic [PRICE_W-1:0] sat40(input logic [73:0] v);
    return (v > 74'(PRICE_MAX)) ? PRICE_MAX : v[PRICE_W-1:0];
  endfunction
endpackage

// ===== rtl/bop_if.sv =====
// Valid/ready channel interfaces for items, results and configuration.
interface bop_in_if;
  import bop_pkg::*;
  logic valid, ready;
  logic [PRICE_W-1:0] spot_price, strike_price;
  logic is_put;
  logic [FACT_W-1:0] up_factor, down_factor, disc_prob_up, disc_prob_down;
  modport source(output valid, spot_price, strike_price, is_put, up_factor,
                 down_factor, disc_prob_up, disc_prob_down, input ready);
  modport sink(input valid, spot_price, strike_price, is_put, up_factor,
               down_factor, disc_prob_up, disc_prob_down, output ready);
endinterface

interface bop_out_if;
  import bop_pkg::*;
  logic valid, ready;
  logic [PRICE_W-1:0] option_value;
  modport source(output valid, option_value, input ready);
  modport sink(input valid, option_value, output ready);
endinterface

interface bop_cfg_if;
  import bop_pkg::*;
  logic valid, ready;
  logic [STEPS_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== rtl/bop_datapath.sv =====
// Datapath: leaf multiplier, payoff, induction and node store.
module bop_datapath import bop_pkg::*; #(
  parameter int AW = 9
) (
  input  logic               clk,
  input  item_t              item,
  input  cmd_t               cmd,
  output logic [PRICE_W-1:0] root
);
  logic [PRICE_W-1:0] mem [2**AW];
  logic [PRICE_W-1:0] leaf, rd0, rd1;
  logic [71:0] prod;
  logic [73:0] rnd;
  logic [71:0] p1, p2;
  logic [73:0] s;
  logic [FACT_W-1:0] f;
  logic [PRICE_W-1:0] pay;
  logic [PRICE_W-1:0] ind;

  assign f = (cmd.op == OP_MULD) ? item.down : item.up;
  assign prod = leaf * f;
  assign rnd = 74'(prod >> 30) + 74'(prod[29]);

  always_comb begin
    if (item.is_put == PAY_PUT) pay = (item.strike > leaf) ? item.strike - leaf : '0;
    else pay = (leaf > item.strike) ? leaf - item.strike : '0;
  end

  // two products of one induction step, registered before the sum
  always_ff @(posedge clk) begin
    p1 <= rd1 * item.pu;
    p2 <= rd0 * item.pd;
  end
  assign s = 74'(p1) + 74'(p2);
  assign ind = sat40((s >> 32) + 74'(s[31]));

  // root keeps the last induction value written to node 0
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: leaf <= item.spot;
      OP_MULD, OP_MULU: leaf <= sat40(rnd);
      OP_LEAF: mem[cmd.addr[AW-1:0]] <= pay;
      OP_IND: begin
        mem[cmd.addr[AW-1:0]] <= ind;
        if (cmd.addr == '0) root <= ind;
      end
      default: ;
    endcase
    if (cmd.op == OP_RD) begin
      rd0 <= mem[cmd.addr[AW-1:0]];
      rd1 <= mem[AW'(cmd.addr[AW-1:0] + 1'b1)];
    end
  end
endmodule

// ===== rtl/bop_ctrl.sv =====
// Controller: sequences leaf generation and backward induction.
module bop_ctrl import bop_pkg::*; #(
  parameter int MAX_STEPS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic [STEPS_W-1:0] steps_cfg,
  input  logic start,
  output logic busy,
  output logic done,
  input  logic done_ack,
  output cmd_t cmd
);
  typedef enum logic [3:0] {S_IDLE, S_DOWN, S_LEAF, S_UP1, S_UP2,
                            S_RD, S_WAIT, S_IND, S_FIN} st_t;
  st_t st;
  logic [12:0] n, i, j, cnt;
  logic [12:0] n_next;

  always_comb begin
    n_next = 13'(steps_cfg);
    if (n_next < 13'd1) n_next = 13'd1;
    if (n_next > 13'(MAX_STEPS)) n_next = 13'(MAX_STEPS);
  end

  assign busy = (st != S_IDLE) || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; done <= 1'b0; cmd <= '{OP_NONE, '0};
      n <= '0; i <= '0; j <= '0; cnt <= '0;
    end else begin
      cmd <= '{OP_NONE, '0};
      if (done && done_ack) done <= 1'b0;
      unique case (st)
        S_IDLE: if (start) begin
          n <= n_next; cnt <= n_next; j <= '0;
          cmd <= '{OP_LOAD, '0}; st <= S_DOWN;
        end
        S_DOWN: if (cnt == 0) st <= S_LEAF;
          else begin cmd <= '{OP_MULD, '0}; cnt <= cnt - 1'b1; end
        S_LEAF: begin
          cmd <= '{OP_LEAF, j};
          if (j == n) begin i <= n; j <= '0; st <= S_RD; end
          else st <= S_UP1;
        end
        S_UP1: begin cmd <= '{OP_MULU, '0}; st <= S_UP2; end
        S_UP2: begin cmd <= '{OP_MULU, '0}; j <= j + 1'b1; st <= S_LEAF; end
        S_RD: begin cmd <= '{OP_RD, j}; st <= S_WAIT; end
        S_WAIT: st <= S_IND;
        S_IND: begin
          cmd <= '{OP_IND, j};
          if (j + 1'b1 == i) begin
            j <= '0;
            if (i == 13'd1) st <= S_FIN;
            else begin i <= i - 1'b1; st <= S_RD; end
          end else begin j <= j + 1'b1; st <= S_RD; end
        end
        // root register is loaded by the last induction write this cycle
        S_FIN: begin done <= 1'b1; st <= S_IDLE; end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/binomial_option_pricer.sv =====
// Binomial option pricer: one root value per item after N steps.
// The result comes from a serial read/multiply/write induction loop, one node update
// at a time, over N = tree_steps clamped to 1..MAX_STEPS.
// One item at a time; the next item is accepted only after the result has been taken.
// Synchronous active-high reset: tree_steps = 64, idle, no result pending.
module binomial_option_pricer import bop_pkg::*; #(
  parameter int MAX_STEPS = 256
) (
  input logic clk,
  input logic rst,
  bop_cfg_if.sink cfg,
  bop_in_if.sink  in_ch,
  bop_out_if.source out_ch
);
  localparam int AW = $clog2(MAX_STEPS + 2);
  logic [STEPS_W-1:0] steps;
  item_t item;
  cmd_t cmd;
  logic busy, done, start;
  logic [PRICE_W-1:0] root;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) steps <= STEPS_RESET;
    else if (cfg.valid) steps <= cfg.data;
  end

  assign in_ch.ready = !busy;
  assign start = in_ch.valid && !busy;
  always_ff @(posedge clk) begin
    if (start) item <= '{in_ch.spot_price, in_ch.strike_price, in_ch.is_put,
      in_ch.up_factor, in_ch.down_factor, in_ch.disc_prob_up, in_ch.disc_prob_down};
  end

  bop_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
    .clk, .rst, .steps_cfg(steps), .start, .busy, .done,
    .done_ack(out_ch.ready), .cmd);

  bop_datapath #(.AW(AW)) u_dp (.clk, .item, .cmd, .root);

  assign out_ch.valid = done;
  assign out_ch.option_value = root;
endmodule

// ===== verif/tb.sv =====
// Testbench for the binomial option pricer: table-driven and random items checked by a predictor.
`timescale 1ns / 1ps
module tb;
  import bop_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  bop_cfg_if cfg_ch();
  bop_in_if  in_ch();
  bop_out_if out_ch();

  binomial_option_pricer dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  localparam int MAX_N = 256;
  localparam logic [63:0] CYCLE_LIMIT = 64'd20_000_000;

  // expected root values, oldest first
  logic [PRICE_W-1:0] price_q[$];
  logic [STEPS_W-1:0] steps_cfg;
  logic [PRICE_W-1:0] nodes[MAX_N+1];
  int errors;
  int send_idle, recv_idle;
  bit recv_hold;
  int hold_cycles;
  logic [63:0] cycle_cnt;

  function automatic logic [PRICE_W-1:0] scale_q30(logic [PRICE_W-1:0] p, logic [31:0] f);
    logic [71:0] prod;
    logic [73:0] r;
    prod = p * f;
    r = 74'(prod >> 30) + 74'(prod[29]);
    return (r > 74'(PRICE_MAX)) ? PRICE_MAX : r[PRICE_W-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] discount_step(logic [31:0] pu, logic [PRICE_W-1:0] vu,
                                                        logic [31:0] pd, logic [PRICE_W-1:0] vd);
    logic [71:0] a;
    logic [71:0] b;
    logic [73:0] s;
    logic [73:0] r;
    a = vu * pu;
    b = vd * pd;
    s = 74'(a) + 74'(b);
    r = (s >> 32) + 74'(s[31]);
    return (r > 74'(PRICE_MAX)) ? PRICE_MAX : r[PRICE_W-1:0];
  endfunction

  function automatic logic [PRICE_W-1:0] price_option(item_t it);
    int n;
    logic [PRICE_W-1:0] leaf;
    n = steps_cfg;
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    leaf = it.spot;
    for (int i = 0; i < n; i++) leaf = scale_q30(leaf, it.down);
    for (int j = 0; j <= n; j++) begin
      if (it.is_put == PAY_PUT) nodes[j] = (it.strike > leaf) ? it.strike - leaf : '0;
      else nodes[j] = (leaf > it.strike) ? leaf - it.strike : '0;
      leaf = scale_q30(scale_q30(leaf, it.up), it.up);
    end
    for (int i = n; i > 0; i--)
      for (int j = 0; j < i; j++)
        nodes[j] = discount_step(it.pu, nodes[j+1], it.pd, nodes[j]);
    return nodes[0];
  endfunction

  // valid stays high after an accept so items can follow back to back
  task automatic send_item(item_t it);
    while (($urandom % 100) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.spot_price <= it.spot;
    in_ch.strike_price <= it.strike;
    in_ch.is_put <= it.is_put;
    in_ch.up_factor <= it.up;
    in_ch.down_factor <= it.down;
    in_ch.disc_prob_up <= it.pu;
    in_ch.disc_prob_down <= it.pd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    price_q.push_back(price_option(it));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (price_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_steps(logic [STEPS_W-1:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    steps_cfg = v;
  endtask

  function automatic item_t rand_item();
    item_t it;
    logic [31:0] u;
    it.spot = {8'($urandom_range(0, 255)), $urandom};
    if ($urandom_range(0, 3) != 0) it.spot = 40'(($urandom_range(1, 500)) << 16) + ($urandom & 16'hFFFF);
    it.strike = ($urandom_range(0, 3) != 0) ? 40'(($urandom_range(1, 500)) << 16)
                                            : {8'($urandom), $urandom};
    it.is_put = 1'($urandom_range(0, 1));
    u = 32'h4000_0000 + $urandom_range(0, 32'h0400_0000);
    it.up = ($urandom_range(0, 7) == 0) ? $urandom : u;
    it.down = ($urandom_range(0, 7) == 0) ? $urandom : 32'h4000_0000 - (u - 32'h4000_0000);
    it.pu = ($urandom_range(0, 7) == 0) ? $urandom : 32'h7F00_0000 + $urandom_range(0, 32'hFFFFFF);
    it.pd = ($urandom_range(0, 7) == 0) ? $urandom : 32'h7F00_0000 + $urandom_range(0, 32'hFFFFFF);
    return it;
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= 0;
    end else if (recv_hold && hold_cycles < 3000) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ch.ready <= (($urandom % 100) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (price_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_ch.option_value);
      end else begin
        if (out_ch.option_value !== price_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("option_value mismatch: expected %h got %h", price_q[0], out_ch.option_value);
        end
        void'(price_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  typedef struct {
    logic [STEPS_W-1:0] steps;
    item_t it;
    bit known;
    logic [PRICE_W-1:0] value;
  } row_t;

  row_t rows[$];
  item_t it;
  logic [STEPS_W-1:0] phase_steps[3] = '{9'd4, 9'd1, 9'd16};

  initial begin
    cycle_cnt = 0;
    errors = 0;
    send_idle = 32; recv_idle = 68;
    recv_hold = 0;
    steps_cfg = STEPS_RESET;
    in_ch.valid = 1'b0;
    in_ch.spot_price = '0; in_ch.strike_price = '0; in_ch.is_put = 1'b0;
    in_ch.up_factor = '0; in_ch.down_factor = '0;
    in_ch.disc_prob_up = '0; in_ch.disc_prob_down = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // steps, spot, strike, put, up, down, pu, pd; value typed where obvious
    rows = '{
      '{STEPS_RESET, '{40'd100<<16, 40'd100<<16, PAY_CALL, 32'h4100_0000, 32'h3F00_0000,
                       32'h7FF0_0000, 32'h7FF0_0000}, 0, '0},
      '{9'd0, '{40'd0, 40'd0, PAY_CALL, 32'h4000_0000, 32'h4000_0000, 32'h8000_0000,
                32'h8000_0000}, 1, '0},
      '{9'd0, '{40'd50<<16, 40'd100<<16, PAY_PUT, 32'h4000_0000, 32'h4000_0000, 32'h8000_0000,
                32'h8000_0000}, 1, 40'd50<<16},
      '{9'd1, '{PRICE_MAX, 40'd0, PAY_CALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF}, 1, PRICE_MAX},
      '{9'd1, '{PRICE_MAX, PRICE_MAX, PAY_PUT, 32'h0, 32'h0, 32'h0, 32'h0}, 1, '0},
      '{9'd1, '{40'd100<<16, 40'd90<<16, PAY_CALL, 32'h4400_0000, 32'h3C00_0000,
                32'h7000_0000, 32'h8F00_0000}, 0, '0},
      '{9'd256, '{40'd100<<16, 40'd100<<16, PAY_PUT, 32'h4020_0000, 32'h3FE0_0000,
                  32'h7FFF_0000, 32'h7FFF_0000}, 0, '0},
      '{9'd511, '{40'd80<<16, 40'd100<<16, PAY_CALL, 32'h4020_0000, 32'h3FE0_0000,
                  32'h7FFF_0000, 32'h7FFF_0000}, 0, '0},
      '{9'd8, '{40'd100<<16, 40'd100<<16, PAY_CALL, 32'h8000_0000, 32'h2000_0000,
                32'hC000_0000, 32'hC000_0000}, 0, '0}
    };
    foreach (rows[i]) begin
      if (rows[i].steps != steps_cfg || i == 0) write_steps(rows[i].steps);
      send_item(rows[i].it);
      if (rows[i].known && price_q[$] !== rows[i].value) begin
        errors++;
        if (errors <= 10) $display("row %0d: predictor gives %h, table %h", i, price_q[$],
                                   rows[i].value);
      end
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 32 : (ph == 1) ? 68 : 0;
      recv_idle = (ph == 0) ? 68 : (ph == 1) ? 32 : 0;
      write_steps(phase_steps[ph]);
      if (ph == 1) recv_hold = 1;
      for (int k = 0; k < 31; k++) begin
        send_item(rand_item());
        if (k == 15) drain();
      end
    end
    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bop_pkg.sv
rtl/bop_if.sv
rtl/bop_datapath.sv
rtl/bop_ctrl.sv
rtl/binomial_option_pricer.sv
verif/tb.sv
